// ===== hw/rtl/pafc_pkg.sv =====
// ----------------------------------------------------------------------------
// pafc_pkg
// Shared types, constants and a helper function for the pressure averaging
// and flow calculation core.
// ----------------------------------------------------------------------------
package pafc_pkg;

  // Field widths of the channels and the configuration port.
  localparam int unsigned AdcW    = 10;
  localparam int unsigned PresW   = 16;
  localparam int unsigned GainW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  // Averaging window. The mean is taken by an arithmetic shift, so the
  // depth must be a power of two.
  localparam int unsigned Window     = 16;
  localparam int unsigned WindowLog2 = $clog2(Window);
  localparam int unsigned SumW       = PresW + WindowLog2;

  // Scaled ADC difference and intermediate pressure widths.
  localparam int unsigned DiffW  = AdcW + 1;
  localparam int unsigned ProdW  = 27;
  localparam int unsigned ScaleW = ProdW - 8;
  localparam int unsigned RawW   = ScaleW + 1;

  // Differential pressure coefficient 0.0980665 in Q0.32.
  localparam int unsigned CoefW = 29;
  localparam logic [CoefW-1:0] DpCoef = 29'd421192410;

  // Square root unit: radicand width, root width and iteration count.
  localparam int unsigned RadW      = 44;
  localparam int unsigned RootW     = RadW / 2;
  localparam int unsigned RootSteps = RadW / 2;
  localparam int unsigned CntW      = $clog2(RootSteps);

  // Flow coefficient scaled by 60, and the flow product.
  localparam int unsigned Fg60W  = GainW + 6;
  localparam int unsigned FprodW = Fg60W + RootW;
  localparam int unsigned MagW   = FprodW + 1 - 24;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ZERO_CODE       = 2'd0,
    CFG_PRESSURE_GAIN   = 2'd1,
    CFG_PRESSURE_OFFSET = 2'd2,
    CFG_FLOW_GAIN       = 2'd3
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_sample;
    logic scale;
    logic window_upd;
    logic mean;
    logic square;
    logic root_step;
    logic flow_mul;
    logic load_out;
  } pafc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } pafc_status_t;

  // Saturate a signed value to the 16-bit pressure range.
  function automatic logic signed [PresW-1:0] sat16(input logic signed [31:0] v);
    logic signed [PresW-1:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[PresW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/pafc_stream_if.sv =====
// ----------------------------------------------------------------------------
// pafc_stream_if
// Valid/ready channel interfaces for ADC sample requests and pressure and
// flow result requests.
// ----------------------------------------------------------------------------
interface pafc_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface pafc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_pressure;
  logic [15:0] filtered_pressure;
  logic [15:0] flow_rate;
  logic        window_full;

  modport source (
    output valid, output raw_pressure, output filtered_pressure,
    output flow_rate, output window_full, input ready
  );
  modport sink (
    input valid, input raw_pressure, input filtered_pressure,
    input flow_rate, input window_full, output ready
  );
endinterface

// ===== hw/rtl/pressure_average_flow_calc_core.sv =====
// Each accepted sample passes through scaling, window update, mean, squaring,
// the 22-step bit-pair square root and flow scaling, one sample at a time.
// The input takes a new sample while the previous result still waits.
// Reset: clears the window position, running sum, fill flag and output valid,
// and restores the configuration registers to their reset values.
// ----------------------------------------------------------------------------
// pressure_average_flow_calc_core
// Top level: ADC sample to pressure, moving-average filter and square-root
// flow estimate, built from a sequencer and a datapath.
// ----------------------------------------------------------------------------
module pressure_average_flow_calc_core
  import pafc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_wdata_i,
  pafc_in_if.sink            in_i,
  pafc_out_if.source         out_o
);

  pafc_cmd_t    cmd;
  pafc_status_t status;

  // Sequencer.
  pafc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic and storage.
  pafc_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .adc_sample_i        (in_i.adc_sample),
    .cmd_i               (cmd),
    .status_o            (status),
    .out_valid_o         (out_o.valid),
    .out_ready_i         (out_o.ready),
    .raw_pressure_o      (out_o.raw_pressure),
    .filtered_pressure_o (out_o.filtered_pressure),
    .flow_rate_o         (out_o.flow_rate),
    .window_full_o       (out_o.window_full)
  );

endmodule

// ===== hw/rtl/pafc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pafc_ctrl
// Sequencer that walks one sample through conversion, window update, mean,
// iterative square root and flow scaling.
// ----------------------------------------------------------------------------
module pafc_ctrl
  import pafc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  pafc_status_t status_i,
  output pafc_cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SCALE  = 8'b0000_0010,
    ST_WINDOW = 8'b0000_0100,
    ST_MEAN   = 8'b0000_1000,
    ST_SQUARE = 8'b0001_0000,
    ST_ROOT   = 8'b0010_0000,
    ST_FLOW   = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // State register and square root iteration counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_sample = 1'b1;
          state_d           = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_WINDOW;
      end
      ST_WINDOW: begin
        cmd_o.window_upd = 1'b1;
        state_d          = ST_MEAN;
      end
      ST_MEAN: begin
        cmd_o.mean = 1'b1;
        state_d    = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        cnt_d        = '0;
        state_d      = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        cnt_d           = cnt_q + CntW'(1);
        if (cnt_q == CntW'(RootSteps - 1)) begin
          state_d = ST_FLOW;
        end
      end
      ST_FLOW: begin
        cmd_o.flow_mul = 1'b1;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        // Hold the result until the output register can take it.
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/pafc_dp.sv =====
// ----------------------------------------------------------------------------
// pafc_dp
// Datapath: configuration registers, pressure conversion, ring-buffer
// moving average, bit-pair square root, flow scaling and output register.
// ----------------------------------------------------------------------------
module pafc_dp
  import pafc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_wdata_i,
  input  logic [AdcW-1:0]    adc_sample_i,
  input  pafc_cmd_t          cmd_i,
  output pafc_status_t       status_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PresW-1:0]   raw_pressure_o,
  output logic [PresW-1:0]   filtered_pressure_o,
  output logic [PresW-1:0]   flow_rate_o,
  output logic               window_full_o
);

  localparam int unsigned PosW = WindowLog2;

  // Configuration registers.
  logic [AdcW-1:0]         zero_code_q;
  logic [GainW-1:0]        pres_gain_q;
  logic signed [PresW-1:0] pres_off_q;
  logic [GainW-1:0]        flow_gain_q;

  // Per-item working registers.
  logic [AdcW-1:0]          sample_q;
  logic signed [ProdW-1:0]  scale_q;
  logic signed [PresW-1:0]  old_q;
  logic signed [PresW-1:0]  raw_q;
  logic signed [PresW-1:0]  filt_q;
  logic [Fg60W-1:0]         fg60_q;
  logic [RadW-1:0]          rem_q;
  logic [RadW-1:0]          res_q;
  logic [RadW-1:0]          bit_q;
  logic [FprodW-1:0]        fprod_q;

  // Window state.
  logic signed [PresW-1:0] ring_q [Window];
  logic signed [SumW-1:0]  sum_q;
  logic [PosW-1:0]         pos_q;
  logic                    full_q;

  // Output register.
  logic                    out_valid_q;
  logic [PresW-1:0]        out_raw_q;
  logic [PresW-1:0]        out_filt_q;
  logic [PresW-1:0]        out_flow_q;
  logic                    out_full_q;

  logic signed [DiffW-1:0]  diff;
  logic signed [27:0]       prod_full;
  logic signed [ScaleW-1:0] scaled;
  logic signed [RawW-1:0]   raw_sum;
  logic signed [PresW-1:0]  raw_d;
  logic signed [SumW-1:0]   sum_d;
  logic signed [SumW-1:0]   mean_sum;
  logic signed [PresW-1:0]  filt_d;
  logic [PresW-1:0]         mag;
  logic [44:0]              rad_full;
  logic [RadW-1:0]          trial;
  logic [FprodW:0]          fround;
  logic [MagW-1:0]          flow_mag;
  logic [PresW-1:0]         flow_d;
  logic                     filt_pos;

  // Configuration writes; upper data bits beyond a register's width drop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_code_q <= 10'd512;
      pres_gain_q <= '0;
      pres_off_q  <= '0;
      flow_gain_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ZERO_CODE:       zero_code_q <= cfg_wdata_i[AdcW-1:0];
        CFG_PRESSURE_GAIN:   pres_gain_q <= cfg_wdata_i[GainW-1:0];
        CFG_PRESSURE_OFFSET: pres_off_q  <= cfg_wdata_i[PresW-1:0];
        CFG_FLOW_GAIN:       flow_gain_q <= cfg_wdata_i[GainW-1:0];
      endcase
    end
  end

  // Raw conversion: (sample - zero) * gain, rounded by 256, plus offset.
  assign diff      = $signed({1'b0, sample_q}) - $signed({1'b0, zero_code_q});
  assign prod_full = 28'(diff) * 28'($signed({1'b0, pres_gain_q}));
  assign scaled    = ScaleW'((scale_q + 27'sd128) >>> 8);
  assign raw_sum   = RawW'(scaled) + RawW'(pres_off_q);
  assign raw_d     = sat16(32'(raw_sum));

  // Running sum; the replaced entry was read in the scale step.
  assign sum_d     = sum_q - SumW'(old_q) + SumW'(raw_d);

  // Mean rounded to nearest, ties upward.
  assign mean_sum = (sum_q + $signed(SumW'(Window / 2))) >>> WindowLog2;
  assign filt_d   = full_q ? sat16(32'(mean_sum)) : raw_q;

  // Magnitude of the filtered pressure and the square root radicand.
  assign mag      = filt_q[PresW-1] ? PresW'(~filt_q + 16'sd1) : PresW'(filt_q);
  assign rad_full = 45'(mag) * 45'(DpCoef);
  assign trial    = res_q + bit_q;

  // Flow magnitude, rounded by 2^24, and signed saturation.
  assign fround   = (FprodW + 1)'(fprod_q) + (FprodW + 1)'(24'h80_0000);
  assign flow_mag = fround[FprodW:24];
  assign filt_pos = !filt_q[PresW-1] && (filt_q != '0);

  always_comb begin
    if (filt_pos) begin
      flow_d = (flow_mag > MagW'(32767)) ? 16'h7FFF : flow_mag[PresW-1:0];
    end else begin
      flow_d = (flow_mag > MagW'(32768)) ? 16'h8000 : PresW'(~flow_mag + MagW'(1));
    end
  end

  // Working registers of one item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      sample_q <= adc_sample_i;
    end
    // The entry about to be replaced reads as zero until the ring has filled.
    if (cmd_i.scale) begin
      scale_q <= prod_full[ProdW-1:0];
      old_q   <= full_q ? ring_q[pos_q] : '0;
    end
    if (cmd_i.window_upd) begin
      raw_q         <= raw_d;
      ring_q[pos_q] <= raw_d;
    end
    if (cmd_i.mean) begin
      filt_q <= filt_d;
    end
    if (cmd_i.square) begin
      rem_q  <= rad_full[RadW-1:0];
      res_q  <= '0;
      bit_q  <= RadW'(1) << (RadW - 2);
      fg60_q <= Fg60W'({flow_gain_q, 6'b0}) - Fg60W'({flow_gain_q, 2'b0});
    end
    // One result bit per step of the square root.
    if (cmd_i.root_step) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.flow_mul) begin
      fprod_q <= FprodW'(fg60_q) * FprodW'(res_q[RootW-1:0]);
    end
  end

  // Window position, fill flag and running sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      pos_q  <= '0;
      full_q <= 1'b0;
    end else if (cmd_i.window_upd) begin
      sum_q <= sum_d;
      if (pos_q == PosW'(Window - 1)) begin
        pos_q  <= '0;
        full_q <= 1'b1;
      end else begin
        pos_q <= pos_q + PosW'(1);
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_raw_q  <= raw_q;
      out_filt_q <= filt_q;
      out_flow_q <= flow_d;
      out_full_q <= full_q;
    end
  end

  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o         = out_valid_q;
  assign raw_pressure_o      = out_raw_q;
  assign filtered_pressure_o = out_filt_q;
  assign flow_rate_o         = out_flow_q;
  assign window_full_o       = out_full_q;

endmodule

// ===== hw/rtl/pafc_checker.sv =====
// ----------------------------------------------------------------------------
// pafc_checker
// Port-level checks of the core, attached to the top level by bind.
// ----------------------------------------------------------------------------
module pafc_checker
  import pafc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [PresW-1:0] raw_pressure_i,
  input logic [PresW-1:0] filtered_pressure_i,
  input logic [PresW-1:0] flow_rate_i,
  input logic             window_full_i
);

  logic seen_full_q;
  logic out_acc;
  logic filt_pos;

  assign out_acc  = out_valid_i && out_ready_i;
  assign filt_pos = $signed(filtered_pressure_i) > 16'sd0;

  // Remember that a full window has been reported.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_full_q <= 1'b0;
    end else if (out_acc && window_full_i) begin
      seen_full_q <= 1'b1;
    end
  end

  // A waiting result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(raw_pressure_i)
      && $stable(filtered_pressure_i) && $stable(flow_rate_i) && $stable(window_full_i))
    else $error("result changed while stalled");

  // The core works on one sample at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("sample taken while busy");

  // Once full, the window stays full.
  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_full_q |-> window_full_i)
    else $error("window full flag dropped");

  // Before the window fills, the filtered value is the raw value.
  a_raw_passthru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !window_full_i |-> filtered_pressure_i == raw_pressure_i)
    else $error("filtered differs from raw before fill");

  // Flow sign follows the filtered pressure.
  a_flow_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (filt_pos && !flow_rate_i[PresW-1])
      || (!filt_pos && (flow_rate_i[PresW-1] || flow_rate_i == '0)))
    else $error("flow sign mismatch");

endmodule

bind pressure_average_flow_calc_core pafc_checker u_pafc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .raw_pressure_i      (out_o.raw_pressure),
  .filtered_pressure_i (out_o.filtered_pressure),
  .flow_rate_i         (out_o.flow_rate),
  .window_full_i       (out_o.window_full)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Sends ADC sample requests through the pressure averaging and flow core
// under several register settings. A model in this file predicts each result
// request, and the results are checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module testbench;
  import pafc_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned IdlePct     = 15;
  localparam int unsigned PhaseCount  = 8;
  localparam int unsigned PhaseLen    = 180;
  localparam int unsigned HoldAt      = 300;
  localparam int unsigned HoldCycles  = 800;
  localparam int unsigned SteadyFrom  = 600;
  localparam int unsigned SteadyTo    = 900;
  localparam int unsigned PrintCap    = 100;
  // 0.0980665 in Q0.32, rounded.
  localparam longint unsigned DpScaleQ32 = 64'd421192410;

  typedef struct packed {
    logic signed [PresW-1:0] raw;
    logic signed [PresW-1:0] filt;
    logic signed [PresW-1:0] flow;
    logic                    full;
  } flow_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDatW-1:0] cfg_wdata_i;

  pafc_in_if  sample_if ();
  pafc_out_if result_if ();

  pressure_average_flow_calc_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (sample_if),
    .out_o       (result_if)
  );

  // Model copy of the registers and of the averaging window.
  logic [AdcW-1:0]         zero_reg;
  logic [GainW-1:0]        pgain_reg;
  logic signed [PresW-1:0] poffs_reg;
  logic [GainW-1:0]        fgain_reg;
  logic signed [PresW-1:0] press_hist [Window];
  int                      hist_sum;
  int unsigned             hist_pos;
  bit                      hist_full;

  // Samples waiting to be sent, and results still owed by the core.
  logic [AdcW-1:0] pending_q [$];
  flow_result_t    expect_q [$];

  int unsigned samples_taken;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned cycle_cnt;
  int unsigned hold_left;
  bit          hold_done;
  bit          offer;
  flow_result_t want;

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Saturate to the signed 16-bit range.
  function automatic logic signed [PresW-1:0] clip16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[PresW-1:0];
  endfunction

  // Largest integer whose square does not exceed v, found bit by bit.
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int k = 23; k >= 0; k--) begin
      trial = root | (64'd1 << k);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Convert one sample, update the window and derive the flow estimate.
  function automatic flow_result_t predict_result(input logic [AdcW-1:0] adc);
    flow_result_t    res;
    longint          scaled;
    longint unsigned mag;
    longint unsigned root;
    longint unsigned flow_mag;
    // Scale with rounding to nearest, ties upward, then add the offset.
    scaled = ((longint'(adc) - longint'(zero_reg)) * longint'(pgain_reg) + 128) >>> 8;
    res.raw = clip16(scaled + longint'(poffs_reg));

    // Replace the oldest window entry and keep the sum current.
    hist_sum = hist_sum - int'(press_hist[hist_pos]) + int'(res.raw);
    press_hist[hist_pos] = res.raw;
    if (hist_pos == Window - 1) begin
      hist_pos  = 0;
      hist_full = 1'b1;
    end else begin
      hist_pos++;
    end

    // Mean once the window has filled, rounded to nearest with ties upward.
    if (hist_full) begin
      res.filt = clip16((2 * longint'(hist_sum) + longint'(Window)) >>> (WindowLog2 + 1));
    end else begin
      res.filt = res.raw;
    end

    // Square-root flow; only a positive pressure gives a positive flow.
    mag = ($signed(res.filt) < 0) ? -longint'(res.filt) : longint'(res.filt);
    root = floor_root(mag * DpScaleQ32);
    flow_mag = (64'd60 * fgain_reg * root + (64'd1 << 23)) >> 24;
    if ($signed(res.filt) > 0) begin
      res.flow = (flow_mag > 32767) ? 16'sh7FFF : clip16(longint'(flow_mag));
    end else begin
      res.flow = (flow_mag > 32768) ? 16'sh8000 : clip16(-longint'(flow_mag));
    end
    res.full = hist_full;
    return res;
  endfunction

  // Write one register and mirror it in the model; only used while idle.
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDatW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    unique case (idx)
      CFG_ZERO_CODE:       zero_reg  = data[AdcW-1:0];
      CFG_PRESSURE_GAIN:   pgain_reg = data;
      CFG_PRESSURE_OFFSET: poffs_reg = data;
      CFG_FLOW_GAIN:       fgain_reg = data;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Block until every queued sample is sent and every result has arrived.
  // The check runs on the falling edge, after the rising-edge updates settle.
  task automatic wait_idle();
    while (pending_q.size() != 0 || sample_if.valid || expect_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] exp_v);
    if (mismatches < PrintCap) begin
      $display("mismatch in %s at result %0d: got %h, expected %h",
               field, results_seen, got, exp_v);
    end
    mismatches++;
  endtask

  // Sample requests: a new one is loaded only once the last was taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sample_if.valid <= 1'b0;
    end else begin
      if (sample_if.valid && sample_if.ready) begin
        expect_q.push_back(predict_result(sample_if.adc_sample));
        samples_taken++;
        offer = 1'b0;
      end else begin
        offer = sample_if.valid;
      end
      if (!offer && pending_q.size() != 0 &&
          ((samples_taken >= SteadyFrom && samples_taken < SteadyTo) ||
           $urandom_range(99) >= IdlePct)) begin
        sample_if.valid      <= 1'b1;
        sample_if.adc_sample <= pending_q.pop_front();
      end else if (!offer) begin
        sample_if.valid      <= 1'b0;
        sample_if.adc_sample <= AdcW'($urandom);
      end
    end
  end

  // One long hold-off of the receiver lets the core fill up and stall its input.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
    end else if (results_seen == HoldAt && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
  end

  // Result requests: compare with the oldest prediction, then pick ready.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (expect_q.size() == 0) begin
          report_mismatch("unexpected result", result_if.raw_pressure, 16'h0);
        end else begin
          want = expect_q.pop_front();
          if (result_if.raw_pressure !== want.raw)
            report_mismatch("raw_pressure", result_if.raw_pressure, want.raw);
          if (result_if.filtered_pressure !== want.filt)
            report_mismatch("filtered_pressure", result_if.filtered_pressure, want.filt);
          if (result_if.flow_rate !== want.flow)
            report_mismatch("flow_rate", result_if.flow_rate, want.flow);
          if (result_if.window_full !== want.full)
            report_mismatch("window_full", {15'b0, result_if.window_full}, {15'b0, want.full});
        end
        results_seen++;
      end
      result_if.ready <= (hold_left == 0) &&
                         ((results_seen >= SteadyFrom && results_seen < SteadyTo) ||
                          $urandom_range(99) >= IdlePct);
    end
  end

  // Guard against a hung core.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus: reset, directed samples, then random phases with new settings.
  initial begin
    logic [AdcW-1:0]    zc;
    logic [GainW-1:0]   pg;
    logic [PresW-1:0]   po;
    logic [GainW-1:0]   fg;
    int                 near;

    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_index_i          = CFG_ZERO_CODE;
    cfg_wdata_i          = '0;
    sample_if.valid      = 1'b0;
    sample_if.adc_sample = '0;
    result_if.ready      = 1'b0;
    zero_reg             = 10'd512;
    pgain_reg            = '0;
    poffs_reg            = '0;
    fgain_reg            = '0;
    hist_sum             = 0;
    hist_pos             = 0;
    hist_full            = 1'b0;
    for (int i = 0; i < Window; i++) press_hist[i] = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: zero gain, so every pressure is the zero offset.
    pending_q.push_back(10'd0);
    pending_q.push_back(10'd1023);
    pending_q.push_back(10'd512);
    wait_idle();

    // Full gains: both saturation limits, the zero point, rounding ties at
    // plus and minus 128 counts, and the first filling of the window.
    write_reg(CFG_ZERO_CODE, {6'h3F, 10'd512});
    write_reg(CFG_PRESSURE_GAIN, 16'hFFFF);
    write_reg(CFG_PRESSURE_OFFSET, 16'h0000);
    write_reg(CFG_FLOW_GAIN, 16'hFFFF);
    pending_q.push_back(10'd1023);
    pending_q.push_back(10'd0);
    pending_q.push_back(10'd512);
    pending_q.push_back(10'd640);
    pending_q.push_back(10'd384);
    pending_q.push_back(10'd513);
    pending_q.push_back(10'd511);
    repeat (5) pending_q.push_back(10'd1023);
    pending_q.push_back(10'd0);
    pending_q.push_back(10'd600);
    pending_q.push_back(10'd700);
    pending_q.push_back(10'd800);
    pending_q.push_back(10'd900);
    wait_idle();

    // Random phases; the first ones use the register extremes.
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: begin
          zc = 10'd0;    pg = 16'hFFFF; po = 16'h7FFF; fg = 16'hFFFF;
        end
        1: begin
          zc = 10'd1023; pg = 16'hFFFF; po = 16'h8000; fg = 16'h0000;
        end
        2: begin
          zc = 10'd512;  pg = 16'h0000; po = 16'($urandom); fg = 16'($urandom);
        end
        default: begin
          zc = AdcW'($urandom);
          pg = $urandom_range(1) ? 16'($urandom_range(2047)) : 16'($urandom);
          po = $urandom_range(1) ? 16'($urandom_range(4095)) - 16'd2048 : 16'($urandom);
          fg = 16'($urandom);
        end
      endcase
      write_reg(CFG_ZERO_CODE, {6'($urandom), zc});
      write_reg(CFG_PRESSURE_GAIN, pg);
      write_reg(CFG_PRESSURE_OFFSET, po);
      write_reg(CFG_FLOW_GAIN, fg);

      // Half the samples cluster around the zero point, the rest are uniform.
      for (int n = 0; n < PhaseLen; n++) begin
        if ($urandom_range(1)) begin
          pending_q.push_back(AdcW'($urandom));
        end else begin
          near = int'(zero_reg) + int'($urandom_range(80)) - 40;
          if (near < 0) near = 0;
          if (near > 1023) near = 1023;
          pending_q.push_back(AdcW'(near));
        end
      end
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expect_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
